>>> rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop at every edge outside reset.
`define BPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check prop at every edge, reset included.
`define BPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BPT_ASSERT(lbl, prop, msg)
`define BPT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/bpt_pkg.sv
package bpt_pkg;

    localparam int DEV_W           = 8;
    localparam int PAGE_W          = 32;
    localparam int CNT_W           = 16;
    localparam int ENTRIES_DEFAULT = 128;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_QUERY    = 2'd0,
        CMD_LOG      = 2'd1,
        CMD_DISMOUNT = 2'd2,
        CMD_REWRITE  = 2'd3
    } t_cmd;

endpackage

>>> rtl/bpt_ram.sv
module bpt_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bad_page_table_core.sv
// Log: the entry is written at the input transfer; the result is then registered from S_DONE.
// Query, dismount, rewrite: one entry read per cycle from the single RAM read port,
// then the result is registered from S_DONE. No new command is taken until then.
// A result stalled at the output holds the next result in S_DONE until it is taken.
// Synchronous active-low reset clears all valid marks, the slot pointer and the counter;
// entry device and page storage is not cleared.
`include "assert_macros.svh"

module bad_page_table_core import bpt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [PAGE_W-1:0] i_page_offset,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_is_bad,
    output logic              o_slot_was_live,
    output logic [CNT_W-1:0]  o_eviction_count
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW = DEV_W + PAGE_W;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [DEV_W-1:0]   r_dev;
    logic [PAGE_W-1:0]  r_page;
    logic [IW-1:0]      r_idx;
    logic               r_issue;
    logic               r_chk_en;
    logic [IW-1:0]      r_chk_idx;
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_next;
    logic [CNT_W-1:0]   r_evict;
    logic               r_bad;
    logic               r_live;
    logic               r_out_valid;
    logic               r_out_bad;
    logic               r_out_live;
    logic [CNT_W-1:0]   r_out_cnt;

    logic               in_xfer;
    logic               out_free;
    logic               ram_we;
    logic [RW-1:0]      ram_rdata;
    logic               dev_hit;
    logic               page_hit;
    logic               slot_valid;

    assign in_xfer    = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ram_we     = in_xfer && (t_cmd'(i_cmd) == CMD_LOG);
    assign dev_hit    = (ram_rdata[RW-1:PAGE_W] == r_dev);
    assign page_hit   = (ram_rdata[PAGE_W-1:0] == r_page);
    assign slot_valid = r_valid[r_chk_idx];

    bpt_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_next),
        .i_wdata ({i_device_id, i_page_offset}),
        .i_re    (r_issue),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_chk_en    <= 1'b0;
            r_valid     <= '0;
            r_next      <= '0;
            r_evict     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_chk_en  <= r_issue;
            r_chk_idx <= r_idx;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd  <= t_cmd'(i_cmd);
                        r_dev  <= i_device_id;
                        r_page <= i_page_offset;
                        r_bad  <= 1'b0;
                        r_live <= (t_cmd'(i_cmd) == CMD_LOG) && r_valid[r_next];
                        if (t_cmd'(i_cmd) == CMD_LOG) begin
                            r_valid[r_next] <= 1'b1;
                            if (r_valid[r_next] && (r_evict != CNT_MAX)) begin
                                r_evict <= r_evict + CNT_W'(1);
                            end
                            r_next  <= (r_next == LAST) ? '0 : r_next + IW'(1);
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= '0;
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_idx == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                    if (r_chk_en) begin
                        if (slot_valid && dev_hit) begin
                            unique case (r_cmd)
                                CMD_QUERY: begin
                                    if (page_hit) begin
                                        r_bad <= 1'b1;
                                    end
                                end
                                CMD_LOG: begin
                                end
                                CMD_DISMOUNT: begin
                                    r_valid[r_chk_idx] <= 1'b0;
                                end
                                CMD_REWRITE: begin
                                    if (page_hit) begin
                                        r_valid[r_chk_idx] <= 1'b0;
                                    end
                                end
                            endcase
                        end
                        if (r_chk_idx == LAST) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_bad   <= r_bad;
                        r_out_live  <= r_live;
                        r_out_cnt   <= r_evict;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_is_bad         = r_out_bad;
    assign o_slot_was_live  = r_out_live;
    assign o_eviction_count = r_out_cnt;

    `BPT_ASSERT(a_accept_busy, (i_in_valid && !o_in_stall) |=> o_in_stall, "transfer not held")
    `BPT_ASSERT(a_flags_exclusive, o_out_valid |-> !(o_is_bad && o_slot_was_live), "both flags")
    `BPT_ASSERT(a_evict_monotonic, $past(i_rst_n) |-> (r_evict >= $past(r_evict)), "count fell")
    `BPT_ASSERT(a_scan_only_in_scan, r_issue |-> (r_state == S_SCAN), "read issued outside scan")

endmodule

>>> dv/bad_page_table_checker.sv
`timescale 1ns / 100ps

module bad_page_table_checker import bpt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [1:0]        i_cmd,
    input  logic [DEV_W-1:0]  i_device_id,
    input  logic [PAGE_W-1:0] i_page_offset,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_is_bad,
    input  logic              i_slot_was_live,
    input  logic [CNT_W-1:0]  i_eviction_count,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic             is_bad;
        logic             slot_was_live;
        logic [CNT_W-1:0] eviction_count;
    } t_page_status;

    logic [DEV_W-1:0]  slot_dev  [ENTRIES];
    logic [PAGE_W-1:0] slot_page [ENTRIES];
    logic              slot_live [ENTRIES];
    int unsigned       log_ptr     = 0;
    logic [CNT_W-1:0]  evict_total = '0;
    t_page_status      status_q [$];
    int                fails       = 0;

    initial o_pending = 0;
    assign o_fail_count = fails;

    task automatic apply_command(input t_cmd op, input logic [DEV_W-1:0] dev,
                                 input logic [PAGE_W-1:0] page, output t_page_status res);
        res = '0;
        case (op)
            CMD_QUERY: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_live[i] && slot_dev[i] == dev && slot_page[i] == page)
                        res.is_bad = 1'b1;
            end
            CMD_LOG: begin
                if (slot_live[log_ptr]) begin
                    res.slot_was_live = 1'b1;
                    if (evict_total != CNT_MAX)
                        evict_total = evict_total + 1'b1;
                end
                slot_dev[log_ptr]  = dev;
                slot_page[log_ptr] = page;
                slot_live[log_ptr] = 1'b1;
                log_ptr = (log_ptr + 1 >= ENTRIES) ? 0 : log_ptr + 1;
            end
            CMD_DISMOUNT: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_live[i] && slot_dev[i] == dev)
                        slot_live[i] = 1'b0;
            end
            default: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (slot_live[i] && slot_dev[i] == dev && slot_page[i] == page)
                        slot_live[i] = 1'b0;
            end
        endcase
        res.eviction_count = evict_total;
    endtask

    always @(posedge i_clk) begin
        t_page_status want;
        t_page_status got;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                slot_live[i] = 1'b0;
            log_ptr     = 0;
            evict_total = '0;
            status_q.delete();
            o_pending   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_is_bad, i_slot_was_live, i_eviction_count};
                if (status_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result transfer with nothing pending: bad=%b live=%b cnt=%0d",
                                 $time, got.is_bad, got.slot_was_live, got.eviction_count);
                end else begin
                    want = status_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch: expected bad=%b live=%b cnt=%0d, got bad=%b live=%b cnt=%0d",
                                     $time, want.is_bad, want.slot_was_live, want.eviction_count,
                                     got.is_bad, got.slot_was_live, got.eviction_count);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_command(t_cmd'(i_cmd), i_device_id, i_page_offset, want);
                status_q.push_back(want);
            end
            o_pending = status_q.size();
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bpt_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEFAULT;
    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 600;
    localparam int FILL_LOGS   = 2 * ENTRIES;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_cmd;
    logic [DEV_W-1:0]  i_device_id;
    logic [PAGE_W-1:0] i_page_offset;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_is_bad;
    logic              o_slot_was_live;
    logic [CNT_W-1:0]  o_eviction_count;

    int                fail_count;
    int                pending;
    int                quiet_cycles = 0;
    bit                sender_idles;
    bit                recv_idles;
    bit                hold_ask;
    logic [DEV_W-1:0]  dev_pool  [6];
    logic [PAGE_W-1:0] page_pool [16];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bad_page_table_core #(.ENTRIES(ENTRIES)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_device_id      (i_device_id),
        .i_page_offset    (i_page_offset),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_bad         (o_is_bad),
        .o_slot_was_live  (o_slot_was_live),
        .o_eviction_count (o_eviction_count)
    );

    bad_page_table_checker #(.ENTRIES(ENTRIES)) bpt_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_device_id      (i_device_id),
        .i_page_offset    (i_page_offset),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_is_bad         (o_is_bad),
        .i_slot_was_live  (o_slot_was_live),
        .i_eviction_count (o_eviction_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int span;
        bit held;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_ask && !held) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall = 1'b0;
                held = 1'b1;
            end else begin
                span = $urandom_range(1, 14);
                i_out_stall = recv_idles && ($urandom_range(0, 2) == 0);
                repeat (span - 1) @(negedge i_clk);
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_command(input t_cmd op, input logic [DEV_W-1:0] dev,
                                input logic [PAGE_W-1:0] page);
        int gap;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = op;
        i_device_id   = dev;
        i_page_offset = page;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_command();
        int               pick;
        t_cmd             op;
        logic [DEV_W-1:0]  dev;
        logic [PAGE_W-1:0] page;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = CMD_LOG;
        else if (pick < 80)
            op = CMD_QUERY;
        else if (pick < 95)
            op = CMD_REWRITE;
        else
            op = CMD_DISMOUNT;
        dev  = ($urandom_range(0, 9) < 8) ? dev_pool[$urandom_range(0, 5)] : DEV_W'($urandom);
        page = ($urandom_range(0, 9) < 8) ? page_pool[$urandom_range(0, 15)] : $urandom;
        send_command(op, dev, page);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_QUERY;
        i_device_id   = '0;
        i_page_offset = '0;
        sender_idles  = 1'b1;
        recv_idles    = 1'b1;
        hold_ask      = 1'b0;
        foreach (dev_pool[k])
            dev_pool[k] = DEV_W'($urandom);
        foreach (page_pool[k])
            page_pool[k] = $urandom;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_command(CMD_QUERY,    8'h00, 32'h0000_0000);
        send_command(CMD_LOG,      8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_LOG,      8'h00, 32'h0000_0000);
        send_command(CMD_QUERY,    8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_QUERY,    8'h00, 32'h0000_0000);
        send_command(CMD_QUERY,    8'hFF, 32'h0000_0000);
        send_command(CMD_QUERY,    8'h00, 32'hFFFF_FFFF);
        send_command(CMD_LOG,      8'h12, 32'h0000_1000);
        send_command(CMD_LOG,      8'h12, 32'h0000_1000);
        send_command(CMD_QUERY,    8'h12, 32'h0000_1000);
        send_command(CMD_REWRITE,  8'h12, 32'h0000_1000);
        send_command(CMD_QUERY,    8'h12, 32'h0000_1000);
        send_command(CMD_REWRITE,  8'h55, 32'hDEAD_BEEF);
        send_command(CMD_LOG,      8'h12, 32'h0000_2000);
        send_command(CMD_LOG,      8'h12, 32'h0000_3000);
        send_command(CMD_DISMOUNT, 8'h12, $urandom);
        send_command(CMD_QUERY,    8'h12, 32'h0000_2000);
        send_command(CMD_QUERY,    8'h12, 32'h0000_3000);
        send_command(CMD_DISMOUNT, 8'h77, 32'h0000_0000);
        send_command(CMD_QUERY,    8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_DISMOUNT, 8'hFF, 32'hFFFF_FFFF);
        send_command(CMD_QUERY,    8'hFF, 32'hFFFF_FFFF);

        for (int n = 0; n < 600; n++) begin
            if (n == 200)
                hold_ask = 1'b1;
            if (n == 400)
                drain_results();
            send_random_command();
        end

        // wrap the table twice so that logs evict live slots
        sender_idles = 1'b0;
        recv_idles   = 1'b0;
        for (int n = 0; n < FILL_LOGS; n++)
            send_command(CMD_LOG, DEV_W'($urandom), $urandom);

        sender_idles = 1'b1;
        recv_idles   = 1'b1;
        for (int n = 0; n < 350; n++)
            send_random_command();

        sender_idles = 1'b0;
        recv_idles   = 1'b0;
        for (int n = 0; n < 200; n++)
            send_random_command();

        i_in_valid = 1'b0;
        wait (pending == 0);
        repeat (ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
